/* rtl/core/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants for the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int NUM_REGIONS = 16;
  localparam int NUM_RECORDS = 32;
  localparam int SIZE_BITS   = 16;
  localparam int ID_BITS     = 16;

  localparam int REGION_IDX_W = $clog2(NUM_REGIONS);
  localparam int REGION_CNT_W = $clog2(NUM_REGIONS + 1);
  localparam int REC_IDX_W    = $clog2(NUM_RECORDS);
  localparam int REC_CNT_W    = $clog2(NUM_RECORDS + 1);
  localparam int SCAN_W       = (REC_CNT_W > REGION_CNT_W) ? REC_CNT_W : REGION_CNT_W;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_ALLOC_SCAN,
    S_ALLOC_SLOT,
    S_ALLOC_WRITE,
    S_FREE_SCAN,
    S_FREE_READ,
    S_FREE_ADD,
    S_RESP
  } state_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [ID_BITS-1:0]      id;
    logic [SIZE_BITS-1:0]    size;
    logic [REGION_IDX_W-1:0] region;
  } rec_t;

endpackage

/* rtl/core/ffra_alu.sv */
// ----------------------------------------------------------------------------
// ffra_alu
// Shared add/subtract unit: first-fit compare, id match and size return.
// ----------------------------------------------------------------------------
module ffra_alu (
  input  ffra_pkg::alu_op_e              op_i,
  input  logic [ffra_pkg::SIZE_BITS-1:0] a_i,
  input  logic [ffra_pkg::SIZE_BITS-1:0] b_i,
  output logic [ffra_pkg::SIZE_BITS-1:0] res_o,
  output logic                           carry_o
);

  logic [ffra_pkg::SIZE_BITS-1:0] b_eff;
  logic [ffra_pkg::SIZE_BITS:0]   sum;

  // carry out of a subtract means a >= b
  always_comb begin
    b_eff = (op_i == ffra_pkg::ALU_SUB) ? ~b_i : b_i;
    sum   = {1'b0, a_i} + {1'b0, b_eff}
          + {{ffra_pkg::SIZE_BITS{1'b0}}, (op_i == ffra_pkg::ALU_SUB)};
  end

  assign res_o   = sum[ffra_pkg::SIZE_BITS-1:0];
  assign carry_o = sum[ffra_pkg::SIZE_BITS];

endmodule

/* rtl/core/ffra_region_table.sv */
// ----------------------------------------------------------------------------
// ffra_region_table
// Free size of each loaded region; one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffra_region_table (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [ffra_pkg::REGION_IDX_W-1:0] waddr_i,
  input  logic [ffra_pkg::SIZE_BITS-1:0]    wdata_i,
  input  logic [ffra_pkg::REGION_IDX_W-1:0] raddr_i,
  output logic [ffra_pkg::SIZE_BITS-1:0]    rdata_o
);

  logic [ffra_pkg::SIZE_BITS-1:0] mem [ffra_pkg::NUM_REGIONS];
  logic [ffra_pkg::SIZE_BITS-1:0] rdata_q;

  // entries above the fill count are never read, so no clearing is needed
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ffra_record_table.sv */
// ----------------------------------------------------------------------------
// ffra_record_table
// Live allocation records: id, size and region in memory, valid bits in flops.
// ----------------------------------------------------------------------------
module ffra_record_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [ffra_pkg::REC_IDX_W-1:0] waddr_i,
  input  ffra_pkg::rec_t                 wdata_i,
  input  logic                           clr_i,
  input  logic [ffra_pkg::REC_IDX_W-1:0] clr_addr_i,
  input  logic [ffra_pkg::REC_IDX_W-1:0] raddr_i,
  output ffra_pkg::rec_t                 rdata_o,
  output logic                           rvalid_o,
  input  logic [ffra_pkg::REC_IDX_W-1:0] probe_addr_i,
  output logic                           probe_vld_o
);

  ffra_pkg::rec_t                    mem [ffra_pkg::NUM_RECORDS];
  ffra_pkg::rec_t                    rdata_q;
  logic [ffra_pkg::NUM_RECORDS-1:0]  valid_q;
  logic [ffra_pkg::NUM_RECORDS-1:0]  valid_d;
  logic                              rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_comb begin
    valid_d = valid_q;
    if (we_i) begin
      valid_d[waddr_i] = 1'b1;
    end
    if (clr_i) begin
      valid_d[clr_addr_i] = 1'b0;
    end
  end

  // valid travels with the read data so the match sees both together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o     = rdata_q;
  assign rvalid_o    = rvalid_q;
  assign probe_vld_o = valid_q[probe_addr_i];

endmodule

/* rtl/core/first_fit_region_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_region_allocator_unit
// First-fit allocator over a loaded region list, with an id-keyed record table.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o   | cmd_i, block_size_i, block_id_i
//  out     | out_valid_o / out_stall_i | status_o, region_index_o, region_remaining_o
//
//  One item at a time; in_stall_o stays high from acceptance until its result is taken.
//  A no-op goes straight to the result; a load writes the region table unless it is full.
//  Allocate finds the first fitting region and first free record slot, then writes both;
//  free finds the id, reads its region and adds the size back. The region scan and the
//  record scan each walk one entry a cycle through the single shared adder.
//  Reset clears the region count and record valid bits at once; no clearing pass.
//  The result is held while out_stall_i is high.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] block_size_i,
  input  logic [15:0] block_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  region_index_o,
  output logic [15:0] region_remaining_o
);

  ffra_pkg::state_e                  state_q, state_d;
  logic [ffra_pkg::REGION_CNT_W-1:0] count_q, count_d;
  logic                              pend_q, pend_d;
  logic [ffra_pkg::SCAN_W-1:0]       issue_q, issue_d;
  logic [ffra_pkg::SCAN_W-1:0]       cand_q, cand_d;
  logic [ffra_pkg::REC_IDX_W-1:0]    slot_q, slot_d;
  logic [ffra_pkg::REGION_IDX_W-1:0] reg_q, reg_d;
  logic [ffra_pkg::SIZE_BITS-1:0]    rem_q, rem_d;
  logic [ffra_pkg::SIZE_BITS-1:0]    size_q, size_d;
  logic [ffra_pkg::ID_BITS-1:0]      id_q, id_d;
  ffra_pkg::status_e                 st_q, st_d;
  logic [ffra_pkg::REGION_IDX_W-1:0] ridx_q, ridx_d;
  logic [ffra_pkg::SIZE_BITS-1:0]    rrem_q, rrem_d;

  logic                              rg_we;
  logic [ffra_pkg::REGION_IDX_W-1:0] rg_waddr;
  logic [ffra_pkg::SIZE_BITS-1:0]    rg_wdata;
  logic [ffra_pkg::REGION_IDX_W-1:0] rg_raddr;
  logic [ffra_pkg::SIZE_BITS-1:0]    rg_rdata;

  logic                              rec_we;
  ffra_pkg::rec_t                    rec_wdata;
  logic                              rec_clr;
  logic [ffra_pkg::REC_IDX_W-1:0]    rec_raddr;
  ffra_pkg::rec_t                    rec_rdata;
  logic                              rec_rvalid;
  logic                              probe_vld;

  ffra_pkg::alu_op_e                 alu_op;
  logic [ffra_pkg::SIZE_BITS-1:0]    alu_a, alu_b, alu_res;
  logic                              alu_carry;

  ffra_alu u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  ffra_region_table u_region (
    .clk_i   (clk_i),
    .we_i    (rg_we),
    .waddr_i (rg_waddr),
    .wdata_i (rg_wdata),
    .raddr_i (rg_raddr),
    .rdata_o (rg_rdata)
  );

  ffra_record_table u_record (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .we_i         (rec_we),
    .waddr_i      (slot_q),
    .wdata_i      (rec_wdata),
    .clr_i        (rec_clr),
    .clr_addr_i   (slot_q),
    .raddr_i      (rec_raddr),
    .rdata_o      (rec_rdata),
    .rvalid_o     (rec_rvalid),
    .probe_addr_i (slot_q),
    .probe_vld_o  (probe_vld)
  );

  assign rec_wdata = '{id: id_q, size: size_q, region: reg_q};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pend_d   = pend_q;
    issue_d  = issue_q;
    cand_d   = cand_q;
    slot_d   = slot_q;
    reg_d    = reg_q;
    rem_d    = rem_q;
    size_d   = size_q;
    id_d     = id_q;
    st_d     = st_q;
    ridx_d   = ridx_q;
    rrem_d   = rrem_q;

    rg_we     = 1'b0;
    rg_waddr  = reg_q;
    rg_wdata  = alu_res;
    rg_raddr  = issue_q[ffra_pkg::REGION_IDX_W-1:0];
    rec_we    = 1'b0;
    rec_clr   = 1'b0;
    rec_raddr = issue_q[ffra_pkg::REC_IDX_W-1:0];
    alu_op    = ffra_pkg::ALU_SUB;
    alu_a     = rg_rdata;
    alu_b     = size_q;

    in_stall_o  = (state_q != ffra_pkg::S_IDLE);
    out_valid_o = (state_q == ffra_pkg::S_RESP);

    unique case (state_q)
      ffra_pkg::S_IDLE: begin
        if (in_valid_i) begin
          size_d  = block_size_i;
          id_d    = block_id_i;
          issue_d = '0;
          pend_d  = 1'b0;
          slot_d  = '0;
          unique case (ffra_pkg::cmd_e'(cmd_i))
            ffra_pkg::CMD_LOAD:  state_d = ffra_pkg::S_LOAD;
            ffra_pkg::CMD_ALLOC: state_d = ffra_pkg::S_ALLOC_SCAN;
            ffra_pkg::CMD_FREE:  state_d = ffra_pkg::S_FREE_SCAN;
            ffra_pkg::CMD_NOP: begin
              st_d    = ffra_pkg::ST_OK;
              ridx_d  = '0;
              rrem_d  = '0;
              state_d = ffra_pkg::S_RESP;
            end
          endcase
        end
      end

      ffra_pkg::S_LOAD: begin
        if (count_q == ffra_pkg::REGION_CNT_W'(ffra_pkg::NUM_REGIONS)) begin
          st_d   = ffra_pkg::ST_FULL;
          ridx_d = '0;
          rrem_d = '0;
        end else begin
          rg_we    = 1'b1;
          rg_waddr = count_q[ffra_pkg::REGION_IDX_W-1:0];
          rg_wdata = size_q;
          st_d     = ffra_pkg::ST_OK;
          ridx_d   = count_q[ffra_pkg::REGION_IDX_W-1:0];
          rrem_d   = size_q;
          count_d  = count_q + 1'b1;
        end
        state_d = ffra_pkg::S_RESP;
      end

      // read of the next candidate is issued in the same cycle as the compare of the previous one
      ffra_pkg::S_ALLOC_SCAN: begin
        if (pend_q && alu_carry) begin
          reg_d   = cand_q[ffra_pkg::REGION_IDX_W-1:0];
          rem_d   = alu_res;
          state_d = ffra_pkg::S_ALLOC_SLOT;
        end else if (issue_q >= ffra_pkg::SCAN_W'(count_q)) begin
          st_d    = ffra_pkg::ST_NOFIT;
          ridx_d  = '0;
          rrem_d  = '0;
          state_d = ffra_pkg::S_RESP;
        end else begin
          issue_d = issue_q + 1'b1;
          cand_d  = issue_q;
          pend_d  = 1'b1;
        end
      end

      ffra_pkg::S_ALLOC_SLOT: begin
        if (!probe_vld) begin
          state_d = ffra_pkg::S_ALLOC_WRITE;
        end else if (slot_q == ffra_pkg::REC_IDX_W'(ffra_pkg::NUM_RECORDS - 1)) begin
          st_d    = ffra_pkg::ST_FULL;
          ridx_d  = '0;
          rrem_d  = '0;
          state_d = ffra_pkg::S_RESP;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end

      ffra_pkg::S_ALLOC_WRITE: begin
        rg_we    = 1'b1;
        rg_wdata = rem_q;
        rec_we   = 1'b1;
        st_d     = ffra_pkg::ST_OK;
        ridx_d   = reg_q;
        rrem_d   = rem_q;
        state_d  = ffra_pkg::S_RESP;
      end

      // id match: difference of zero on a valid record
      ffra_pkg::S_FREE_SCAN: begin
        alu_a = id_q;
        alu_b = rec_rdata.id;
        if (pend_q && rec_rvalid && (alu_res == '0)) begin
          reg_d   = rec_rdata.region;
          rem_d   = rec_rdata.size;
          slot_d  = cand_q[ffra_pkg::REC_IDX_W-1:0];
          state_d = ffra_pkg::S_FREE_READ;
        end else if (issue_q == ffra_pkg::SCAN_W'(ffra_pkg::NUM_RECORDS)) begin
          st_d    = ffra_pkg::ST_NOTFOUND;
          ridx_d  = '0;
          rrem_d  = '0;
          state_d = ffra_pkg::S_RESP;
        end else begin
          issue_d = issue_q + 1'b1;
          cand_d  = issue_q;
          pend_d  = 1'b1;
        end
      end

      ffra_pkg::S_FREE_READ: begin
        rg_raddr = reg_q;
        state_d  = ffra_pkg::S_FREE_ADD;
      end

      ffra_pkg::S_FREE_ADD: begin
        alu_op  = ffra_pkg::ALU_ADD;
        alu_b   = rem_q;
        rg_we   = 1'b1;
        rec_clr = 1'b1;
        st_d    = ffra_pkg::ST_OK;
        ridx_d  = reg_q;
        rrem_d  = alu_res;
        state_d = ffra_pkg::S_RESP;
      end

      ffra_pkg::S_RESP: begin
        if (!out_stall_i) begin
          state_d = ffra_pkg::S_IDLE;
        end
      end

      default: state_d = ffra_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffra_pkg::S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q <= issue_d;
    cand_q  <= cand_d;
    slot_q  <= slot_d;
    reg_q   <= reg_d;
    rem_q   <= rem_d;
    size_q  <= size_d;
    id_q    <= id_d;
    st_q    <= st_d;
    ridx_q  <= ridx_d;
    rrem_q  <= rrem_d;
  end

  assign status_o           = st_q;
  assign region_index_o     = ridx_q;
  assign region_remaining_o = rrem_q;

endmodule
